### hdl/fvn3_pkg.sv
// Shared constants, types and helpers for the fractal value noise unit.
// No dependencies.
package fvn3_pkg;

    localparam int OCTAVE_COUNT  = 4;
    localparam int FRACTION_BITS = 16;

    localparam int FRAC_DOWN = (FRACTION_BITS > 16) ? (FRACTION_BITS - 16) : 0;
    localparam int FRAC_UP   = (FRACTION_BITS < 16) ? (16 - FRACTION_BITS) : 0;

    localparam logic [31:0] SEED_STEP = 32'd1013;
    localparam logic [31:0] HASH_KX   = 32'h9E3779B1;
    localparam logic [31:0] HASH_KY   = 32'h85EBCA77;
    localparam logic [31:0] HASH_KZ   = 32'hC2B2AE3D;
    localparam logic [31:0] HASH_M1   = 32'h7FEB352D;
    localparam logic [31:0] HASH_M2   = 32'h846CA68B;

    // Octave sum and exact divide by 2^OCTAVE_COUNT - 1 via reciprocal
    localparam int SUM_W   = 16 + OCTAVE_COUNT;
    localparam int DIV_K   = SUM_W + OCTAVE_COUNT;
    localparam int RECIP_W = DIV_K + 1;
    localparam longint DIVISOR = (longint'(1) << OCTAVE_COUNT) - 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << DIV_K) + DIVISOR - 1) / DIVISOR);

    typedef logic [31:0] word_t;
    typedef logic [15:0] q16_t;

    // Lattice index: low 32 bits of floor(coord * 2^oct / 2^FRACTION_BITS)
    function automatic word_t cell_of(input word_t c, input int oct);
        logic [63:0] v;
        v = {{32{c[31]}}, c} << oct;
        return v[FRACTION_BITS +: 32];
    endfunction

    // Fraction brought to Q0.16
    function automatic q16_t frac_of(input word_t c, input int oct);
        logic [63:0] v;
        logic [63:0] m;
        v = {{32{c[31]}}, c} << oct;
        m = v & ((64'd1 << FRACTION_BITS) - 64'd1);
        return 16'((m >> FRAC_DOWN) << FRAC_UP);
    endfunction

endpackage

### hdl/fvn3_corner_hash.sv
// Two-stage integer mixer for one lattice corner; yields the corner value.
// Depends on fvn3_pkg.
module fvn3_corner_hash (
    input  logic                aclk,
    input  logic                en,
    input  fvn3_pkg::word_t     seed,
    input  fvn3_pkg::word_t     xk,
    input  fvn3_pkg::word_t     yk,
    input  fvn3_pkg::word_t     zk,
    output fvn3_pkg::q16_t      value
);
    fvn3_pkg::word_t h0;
    fvn3_pkg::word_t g1;
    fvn3_pkg::word_t h1_reg, h1_next;
    fvn3_pkg::word_t h2_reg, h2_next;

    always_comb begin
        h0      = seed ^ xk ^ yk ^ zk;
        h0      = h0 ^ (h0 >> 16);
        h1_next = h0 * fvn3_pkg::HASH_M1;
        g1      = h1_reg ^ (h1_reg >> 15);
        h2_next = g1 * fvn3_pkg::HASH_M2;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h1_reg <= h1_next;
            h2_reg <= h2_next;
        end
    end

    // final xorshift leaves the top half untouched
    assign value = h2_reg[31:16];

endmodule

### hdl/fractal_value_noise_3d_unit.sv
// Top level of the four-octave 3D fractal value noise unit.
// Depends on fvn3_pkg and fvn3_corner_hash.
//
// Takes one signed fixed-point point per transaction and returns one Q0.16 noise
// value. All octaves and all eight corners are evaluated in parallel in a
// nine-stage pipeline: split, coordinate multiply, two mixer stages, three
// interpolation stages, octave sum, and reciprocal divide into the output
// register. The whole pipeline advances together and takes a new point every
// cycle; it halts only while a result is held unaccepted. The user must write
// the seed on the cfg channel only while idle; the block does not enforce it.
module fractal_value_noise_3d_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_coord_x,
    input  logic [31:0] s_coord_y,
    input  logic [31:0] s_coord_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_noise_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_noise_seed
);
    localparam int OC = fvn3_pkg::OCTAVE_COUNT;
    localparam int NST = 9;

    logic en;
    logic [NST-1:0] vld_reg, vld_next;
    fvn3_pkg::word_t seed_reg;

    fvn3_pkg::word_t s_coord [3];
    fvn3_pkg::word_t a_cell_reg [OC][3];
    fvn3_pkg::q16_t  a_frac_reg [OC][3];
    fvn3_pkg::word_t b_prod_reg [OC][3];
    fvn3_pkg::word_t b_tt_reg   [OC][3];
    fvn3_pkg::q16_t  b_frac_reg [OC][3];
    fvn3_pkg::q16_t  c_ease_reg [OC][3];
    fvn3_pkg::q16_t  d_ease_reg [OC][3];
    fvn3_pkg::q16_t  e_ease_reg [OC][2];
    fvn3_pkg::q16_t  f_tz_reg   [OC];
    fvn3_pkg::q16_t  d_corner   [OC][8];
    fvn3_pkg::q16_t  e_lerp_reg [OC][4];
    fvn3_pkg::q16_t  f_lerp_reg [OC][2];
    fvn3_pkg::q16_t  g_noise_reg [OC];
    logic [fvn3_pkg::SUM_W-1:0] h_sum_reg, h_sum_next;
    logic [fvn3_pkg::SUM_W+fvn3_pkg::RECIP_W-1:0] quot_prod;
    logic [fvn3_pkg::SUM_W+fvn3_pkg::RECIP_W-1:0] quot;
    logic [15:0] out_reg, out_next;

    function automatic fvn3_pkg::q16_t blend(input fvn3_pkg::q16_t a,
                                             input fvn3_pkg::q16_t b,
                                             input fvn3_pkg::q16_t t);
        logic [32:0] v;
        v = 33'(a) * 33'(17'h10000 - {1'b0, t}) + 33'(b) * 33'(t);
        return v[31:16];
    endfunction

    function automatic fvn3_pkg::q16_t ease(input fvn3_pkg::word_t tt,
                                            input fvn3_pkg::q16_t t);
        logic [17:0] k;
        logic [49:0] p;
        k = 18'h30000 - {1'b0, t, 1'b0};
        p = 50'(tt) * 50'(k);
        return (p[49:32] > 18'hFFFF) ? 16'hFFFF : p[47:32];
    endfunction

    assign en        = !vld_reg[NST-1] || m_ready;
    assign s_ready   = en;
    assign m_valid   = vld_reg[NST-1];
    assign m_noise_out = out_reg;
    assign cfg_ready = 1'b1;

    assign s_coord[0] = s_coord_x;
    assign s_coord[1] = s_coord_y;
    assign s_coord[2] = s_coord_z;

    assign vld_next = {vld_reg[NST-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            seed_reg <= '0;
        end else begin
            if (en) vld_reg <= vld_next;
            if (cfg_valid) seed_reg <= cfg_noise_seed;
        end
    end

    for (genvar o = 0; o < OC; o++) begin : g_oct
        fvn3_pkg::word_t seed_o;
        assign seed_o = seed_reg + 32'(o) * fvn3_pkg::SEED_STEP;

        for (genvar d = 0; d < 3; d++) begin : g_dim
            fvn3_pkg::word_t kmul;
            assign kmul = (d == 0) ? fvn3_pkg::HASH_KX :
                          (d == 1) ? fvn3_pkg::HASH_KY : fvn3_pkg::HASH_KZ;
            always_ff @(posedge aclk) begin
                if (en) begin
                    a_cell_reg[o][d] <= fvn3_pkg::cell_of(s_coord[d], o);
                    a_frac_reg[o][d] <= fvn3_pkg::frac_of(s_coord[d], o);
                    b_prod_reg[o][d] <= a_cell_reg[o][d] * kmul;
                    b_tt_reg[o][d]   <= 32'(a_frac_reg[o][d]) * 32'(a_frac_reg[o][d]);
                    b_frac_reg[o][d] <= a_frac_reg[o][d];
                    c_ease_reg[o][d] <= ease(b_tt_reg[o][d], b_frac_reg[o][d]);
                    d_ease_reg[o][d] <= c_ease_reg[o][d];
                end
            end
        end

        for (genvar c = 0; c < 8; c++) begin : g_corner
            fvn3_pkg::word_t xk, yk, zk;
            // neighbour product: (i + 1) * K = i * K + K
            assign xk = b_prod_reg[o][0] + (((c >> 0) & 1) != 0 ? fvn3_pkg::HASH_KX : 32'd0);
            assign yk = b_prod_reg[o][1] + (((c >> 1) & 1) != 0 ? fvn3_pkg::HASH_KY : 32'd0);
            assign zk = b_prod_reg[o][2] + (((c >> 2) & 1) != 0 ? fvn3_pkg::HASH_KZ : 32'd0);

            fvn3_corner_hash u_hash (
                .aclk  (aclk),
                .en    (en),
                .seed  (seed_o),
                .xk    (xk),
                .yk    (yk),
                .zk    (zk),
                .value (d_corner[o][c])
            );
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int j = 0; j < 4; j++) begin
                    e_lerp_reg[o][j] <= blend(d_corner[o][2*j], d_corner[o][2*j+1],
                                              d_ease_reg[o][0]);
                end
                e_ease_reg[o][0] <= d_ease_reg[o][1];
                e_ease_reg[o][1] <= d_ease_reg[o][2];
                for (int k = 0; k < 2; k++) begin
                    f_lerp_reg[o][k] <= blend(e_lerp_reg[o][2*k], e_lerp_reg[o][2*k+1],
                                              e_ease_reg[o][0]);
                end
                f_tz_reg[o]    <= e_ease_reg[o][1];
                g_noise_reg[o] <= blend(f_lerp_reg[o][0], f_lerp_reg[o][1], f_tz_reg[o]);
            end
        end
    end

    // weight octave o by 2^(OC-1-o), then divide by the total weight
    always_comb begin
        h_sum_next = '0;
        for (int o = 0; o < OC; o++) begin
            h_sum_next = h_sum_next +
                (fvn3_pkg::SUM_W'(g_noise_reg[o]) << (OC - 1 - o));
        end
        quot_prod = (fvn3_pkg::SUM_W + fvn3_pkg::RECIP_W)'(h_sum_reg) *
                    (fvn3_pkg::SUM_W + fvn3_pkg::RECIP_W)'(fvn3_pkg::RECIP);
        quot      = quot_prod >> fvn3_pkg::DIV_K;
        out_next  = (quot > 65535) ? 16'hFFFF : quot[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_sum_reg <= h_sum_next;
            out_reg   <= out_next;
        end
    end

endmodule

### hdl/fvn3_checker.sv
// Port-level checks for fractal_value_noise_3d_unit, bound to the top level.
// Depends on fractal_value_noise_3d_unit.
module fvn3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_noise_out
);
    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_noise_out))
        else $error("result changed while stalled");

    // drop out of reset with no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

bind fractal_value_noise_3d_unit fvn3_checker u_fvn3_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_noise_out (m_noise_out)
);
